// ----- rtl/assert_macros.svh -----
// Assertion macros used by the page allocator back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked at every clock edge outside reset.
`define ACPA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
// Condition in one cycle implies a condition in the next cycle.
`define ACPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- rtl/acpa_pkg.sv -----
// Package with constants, types and helpers of the page allocator.
package acpa_pkg;
   localparam int MAX_PAGES = 4096;
   localparam int ADDR_W = $clog2(MAX_PAGES);
   localparam int CNT_W = 13;
   localparam int PAGE_W = 40;
   localparam int CAND_W = 14;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MANAGED_PAGES = 4'd1;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK, STATUS_BAD_REQUEST, STATUS_NO_RUN, STATUS_NOT_ALLOC
   } status_type;

   typedef enum logic [1:0] {
      KIND_BAD, KIND_ALLOC, KIND_FREE, KIND_FREE_BAD
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_A_TEST, ST_A_ISSUE, ST_A_CHECK, ST_A_WRITE,
      ST_F_ISSUE, ST_F_CHECK, ST_F_WRITE, ST_RESP
   } state_type;

   typedef struct packed {
      kind_type          kind;
      logic [CNT_W-1:0]  run;
      logic [3:0]        align;
      logic [CAND_W-1:0] pos;
   } job_type;

   typedef struct packed {
      logic [PAGE_W-1:0] base;
      logic [CNT_W-1:0]  size;
   } window_type;

   function automatic logic [CAND_W-1:0] aligned_offset(
      input logic [PAGE_W:0] abs_page, input logic [3:0] k, input logic [PAGE_W-1:0] b);
      logic [PAGE_W+1:0] a_m1;
      logic [PAGE_W+1:0] up;
      logic [PAGE_W+1:0] diff;
      a_m1 = (42'd1 << k) - 42'd1;
      up = ({1'b0, abs_page} + a_m1) & ~a_m1;
      diff = up - {2'b0, b};
      if (diff > {{(PAGE_W+2-CAND_W){1'b0}}, {CAND_W{1'b1}}}) begin
         return {CAND_W{1'b1}};
      end
      return diff[CAND_W-1:0];
   endfunction
endpackage

// ----- rtl/acpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module acpa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/acpa_front.sv -----
// Request front end: classifies requests and queues them for the back end.
module acpa_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [acpa_pkg::CNT_W-1:0]     req_run_pages,
   input  logic [3:0]                     req_align_log2,
   input  logic [acpa_pkg::PAGE_W-1:0]    req_free_start_page,
   input  acpa_pkg::window_type           window,
   output logic                           job_valid,
   output acpa_pkg::job_type              job,
   input  logic                           job_pop
);
   acpa_pkg::job_type q_ff [2];
   logic              rd_ptr_ff, rd_ptr_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   acpa_pkg::job_type new_job;
   logic [acpa_pkg::PAGE_W-1:0] off;
   logic              range_ok;
   logic              push;

   always_comb begin
      off = req_free_start_page - window.base;
      range_ok = (req_free_start_page >= window.base)
         && (off <= {27'b0, window.size})
         && (req_run_pages <= window.size - off[acpa_pkg::CNT_W-1:0]);
      new_job.run = req_run_pages;
      new_job.align = req_align_log2;
      if (req_run_pages == '0) begin
         new_job.kind = acpa_pkg::KIND_BAD;
         new_job.pos = '0;
      end else if (req_command == acpa_pkg::CMD_ALLOC) begin
         new_job.kind = acpa_pkg::KIND_ALLOC;
         new_job.pos = acpa_pkg::aligned_offset({1'b0, window.base}, req_align_log2,
            window.base);
      end else begin
         new_job.kind = range_ok ? acpa_pkg::KIND_FREE : acpa_pkg::KIND_FREE_BAD;
         new_job.pos = off[acpa_pkg::CAND_W-1:0];
      end
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ (job_pop && job_valid);
      wr_ptr_in = wr_ptr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, job_pop && job_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end
endmodule

// ----- rtl/acpa_back.sv -----
// Back end: bitmap search, marking, free count, clearing pass and result register.
`include "assert_macros.svh"
module acpa_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rebuild,
   input  acpa_pkg::window_type        window,
   input  logic                        job_valid,
   input  acpa_pkg::job_type           job,
   output logic                        job_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [acpa_pkg::PAGE_W-1:0] rsp_alloc_start_page,
   output logic [acpa_pkg::CNT_W-1:0]  rsp_free_pages
);
   acpa_pkg::state_type state_ff, state_in;
   acpa_pkg::job_type   cur_ff, cur_in;
   logic [acpa_pkg::CNT_W-1:0]  j_ff, j_in;
   logic [acpa_pkg::CAND_W-1:0] cand_ff, cand_in;
   logic [acpa_pkg::CNT_W-1:0]  clr_ff, clr_in;
   logic [acpa_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   acpa_pkg::status_type        res_status_ff, res_status_in;
   logic [acpa_pkg::PAGE_W-1:0] res_first_ff, res_first_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   acpa_pkg::status_type        out_status_ff, out_status_in;
   logic [acpa_pkg::PAGE_W-1:0] out_first_ff, out_first_in;
   logic [acpa_pkg::CNT_W-1:0]  out_free_ff, out_free_in;
   logic [acpa_pkg::CAND_W:0]   run_end;
   logic [acpa_pkg::CAND_W:0]   j_next;
   logic                        wr_en, wr_data, ram_rd_data;
   logic [acpa_pkg::ADDR_W-1:0] wr_addr, rd_addr;

   acpa_ram #(.WIDTH(1), .DEPTH(acpa_pkg::MAX_PAGES)) u_map (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(ram_rd_data)
   );

   assign run_end = {1'b0, cand_ff} + {2'b0, cur_ff.run};
   assign j_next = {2'b0, j_ff} + 15'd1;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      j_in = j_ff;
      cand_in = cand_ff;
      clr_in = clr_ff;
      cnt_in = cnt_ff;
      res_status_in = res_status_ff;
      res_first_in = res_first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_first_in = out_first_ff;
      out_free_in = out_free_ff;
      job_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = j_ff[acpa_pkg::ADDR_W-1:0];
      wr_data = 1'b0;
      rd_addr = j_ff[acpa_pkg::ADDR_W-1:0];
      unique case (state_ff)
         acpa_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[acpa_pkg::ADDR_W-1:0];
            wr_data = (clr_ff < window.size);
            clr_in = clr_ff + 13'd1;
            if (clr_ff[acpa_pkg::ADDR_W-1:0] == {acpa_pkg::ADDR_W{1'b1}}) begin
               cnt_in = window.size;
               state_in = acpa_pkg::ST_IDLE;
            end
         end
         acpa_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               cur_in = job;
               cand_in = job.pos;
               j_in = job.pos[acpa_pkg::CNT_W-1:0];
               res_first_in = '0;
               unique case (job.kind)
                  acpa_pkg::KIND_BAD: begin
                     res_status_in = acpa_pkg::STATUS_BAD_REQUEST;
                     state_in = acpa_pkg::ST_RESP;
                  end
                  acpa_pkg::KIND_ALLOC: state_in = acpa_pkg::ST_A_TEST;
                  acpa_pkg::KIND_FREE: state_in = acpa_pkg::ST_F_ISSUE;
                  default: begin
                     res_status_in = acpa_pkg::STATUS_NOT_ALLOC;
                     state_in = acpa_pkg::ST_RESP;
                  end
               endcase
            end
         end
         acpa_pkg::ST_A_TEST: begin
            if (({1'b0, cand_ff} <= {2'b0, window.size})
                  && ({1'b0, cur_ff.run} <= ({1'b0, window.size} - cand_ff))) begin
               j_in = cand_ff[acpa_pkg::CNT_W-1:0];
               state_in = acpa_pkg::ST_A_ISSUE;
            end else begin
               res_status_in = acpa_pkg::STATUS_NO_RUN;
               state_in = acpa_pkg::ST_RESP;
            end
         end
         acpa_pkg::ST_A_ISSUE: state_in = acpa_pkg::ST_A_CHECK;
         acpa_pkg::ST_A_CHECK: begin
            if (ram_rd_data) begin
               if (j_next == run_end) begin
                  j_in = cand_ff[acpa_pkg::CNT_W-1:0];
                  state_in = acpa_pkg::ST_A_WRITE;
               end else begin
                  j_in = j_next[acpa_pkg::CNT_W-1:0];
                  state_in = acpa_pkg::ST_A_ISSUE;
               end
            end else begin
               cand_in = acpa_pkg::aligned_offset(
                  {1'b0, window.base} + {28'b0, j_ff} + 41'd1, cur_ff.align, window.base);
               state_in = acpa_pkg::ST_A_TEST;
            end
         end
         acpa_pkg::ST_A_WRITE: begin
            wr_en = 1'b1;
            j_in = j_next[acpa_pkg::CNT_W-1:0];
            if (j_next == run_end) begin
               cnt_in = cnt_ff - cur_ff.run;
               res_first_in = window.base + {26'b0, cand_ff};
               res_status_in = acpa_pkg::STATUS_OK;
               state_in = acpa_pkg::ST_RESP;
            end
         end
         acpa_pkg::ST_F_ISSUE: state_in = acpa_pkg::ST_F_CHECK;
         acpa_pkg::ST_F_CHECK: begin
            if (ram_rd_data) begin
               res_status_in = acpa_pkg::STATUS_NOT_ALLOC;
               state_in = acpa_pkg::ST_RESP;
            end else if (j_next == run_end) begin
               j_in = cand_ff[acpa_pkg::CNT_W-1:0];
               state_in = acpa_pkg::ST_F_WRITE;
            end else begin
               j_in = j_next[acpa_pkg::CNT_W-1:0];
               state_in = acpa_pkg::ST_F_ISSUE;
            end
         end
         acpa_pkg::ST_F_WRITE: begin
            wr_en = 1'b1;
            wr_data = 1'b1;
            j_in = j_next[acpa_pkg::CNT_W-1:0];
            if (j_next == run_end) begin
               cnt_in = cnt_ff + cur_ff.run;
               res_status_in = acpa_pkg::STATUS_OK;
               state_in = acpa_pkg::ST_RESP;
            end
         end
         acpa_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_status_in = res_status_ff;
               out_first_in = res_first_ff;
               out_free_in = cnt_ff;
               state_in = acpa_pkg::ST_IDLE;
            end
         end
         default: state_in = acpa_pkg::ST_CLEAR;
      endcase
      if (rebuild) begin
         state_in = acpa_pkg::ST_CLEAR;
         clr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acpa_pkg::ST_CLEAR;
         clr_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      j_ff <= j_in;
      cand_ff <= cand_in;
      res_status_ff <= res_status_in;
      res_first_ff <= res_first_in;
      out_status_ff <= out_status_in;
      out_first_ff <= out_first_in;
      out_free_ff <= out_free_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_alloc_start_page = out_first_ff;
   assign rsp_free_pages = out_free_ff;

   `ACPA_ASSERT(a_write_in_run, (state_ff == acpa_pkg::ST_A_WRITE) |-> ({2'b0, j_ff} < run_end))
   `ACPA_ASSERT(a_err_no_page, (rsp_valid_ff && (out_status_ff != acpa_pkg::STATUS_OK)) |-> (out_first_ff == '0))
   `ACPA_ASSERT(a_no_pop_clear, (state_ff == acpa_pkg::ST_CLEAR) |-> !job_pop)
   `ACPA_ASSERT_NEXT(a_miss_retest, (state_ff == acpa_pkg::ST_A_CHECK) && !ram_rd_data && !rebuild, state_ff == acpa_pkg::ST_A_TEST)
endmodule

// ----- rtl/aligned_contiguous_page_allocator_top.sv -----
// Top level of the aligned contiguous page allocator.
// First-fit page allocator over a window of up to 4096 pages, one bit per page in a RAM.
// An allocate tests each aligned candidate, reads its bitmap pages one at a time
// and then marks the run page by page; a free checks that each page of the run is
// allocated and then releases the pages one by one, with one result register.
// After reset and after every write to the base-page or managed-pages register, a
// clearing pass over the whole bitmap rebuilds it, during which queued requests wait.
module aligned_contiguous_page_allocator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [acpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [acpa_pkg::PAGE_W-1:0]       csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [acpa_pkg::CNT_W-1:0]        req_run_pages,
   input  logic [3:0]                        req_align_log2,
   input  logic [acpa_pkg::PAGE_W-1:0]       req_free_start_page,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [acpa_pkg::PAGE_W-1:0]       rsp_alloc_start_page,
   output logic [acpa_pkg::CNT_W-1:0]        rsp_free_pages
);
   logic [acpa_pkg::PAGE_W-1:0] base_ff, base_in;
   logic [acpa_pkg::CNT_W-1:0]  managed_ff, managed_in;
   logic                        rebuild;
   acpa_pkg::window_type        window;
   logic [acpa_pkg::CNT_W-1:0]  capped;
   logic [acpa_pkg::PAGE_W:0]   limit;
   logic                        job_valid, job_pop;
   acpa_pkg::job_type           job;

   assign csr_ready = 1'b1;

   always_comb begin
      base_in = base_ff;
      managed_in = managed_ff;
      rebuild = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            acpa_pkg::CSR_BASE_PAGE: begin
               base_in = csr_data;
               rebuild = 1'b1;
            end
            acpa_pkg::CSR_MANAGED_PAGES: begin
               managed_in = csr_data[acpa_pkg::CNT_W-1:0];
               rebuild = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 40'd1;
         managed_ff <= '0;
      end else begin
         base_ff <= base_in;
         managed_ff <= managed_in;
      end
   end

   always_comb begin
      window.base = (base_ff == '0) ? 40'd1 : base_ff;
      capped = (managed_ff > 13'(acpa_pkg::MAX_PAGES)) ? 13'(acpa_pkg::MAX_PAGES) : managed_ff;
      limit = {1'b1, 40'b0} - {1'b0, window.base};
      window.size = ({28'b0, capped} > limit) ? limit[acpa_pkg::CNT_W-1:0] : capped;
   end

   acpa_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_run_pages(req_run_pages), .req_align_log2(req_align_log2),
      .req_free_start_page(req_free_start_page), .window(window),
      .job_valid(job_valid), .job(job), .job_pop(job_pop)
   );

   acpa_back u_back (
      .clock(clock), .reset(reset), .rebuild(rebuild), .window(window),
      .job_valid(job_valid), .job(job), .job_pop(job_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_alloc_start_page(rsp_alloc_start_page), .rsp_free_pages(rsp_free_pages)
   );
endmodule
